// ===== sv/dttf_pkg.sv =====
// Package for the decimal text scanner: codes, microcode word and program table.
`default_nettype none
package dttf_pkg;

  localparam int TEXT_W  = 8;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 8;
  localparam int PC_W    = 4;
  localparam int EXP_W   = 7;

  localparam logic [TEXT_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [TEXT_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [TEXT_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [TEXT_W-1:0] CH_E_LO  = 8'h65;
  localparam logic [TEXT_W-1:0] CH_E_UP  = 8'h45;
  localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
  localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
  localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
  localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_SPACE    = 7'b0000010,
    PH_INT      = 7'b0000100,
    PH_FRAC     = 7'b0001000,
    PH_EXP_E    = 7'b0010000,
    PH_EXP_SIGN = 7'b0100000,
    PH_EXP_D1   = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_FETCH    = 4'd1,
    OP_DECODE   = 4'd2,
    OP_LOAD_W   = 4'd3,
    OP_DIV_STEP = 4'd4,
    OP_STORE_W  = 4'd5,
    OP_MUL10    = 4'd6,
    OP_LOAD_M   = 4'd7,
    OP_STORE_M  = 4'd8,
    OP_EMIT     = 4'd9
  } uop_t;

  typedef enum logic [3:0] {
    C_NEXT     = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_XFER  = 4'd2,
    C_NO_FRAC  = 4'd3,
    C_DIV_MORE = 4'd4,
    C_NO_EMIT  = 4'd5,
    C_EXP_DONE = 4'd6,
    C_EXP_NEG  = 4'd7,
    C_OUT_BUSY = 4'd8
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // program steps
  localparam logic [PC_W-1:0] PC_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] PC_DECODE = 4'd1;
  localparam logic [PC_W-1:0] PC_TFRAC  = 4'd2;
  localparam logic [PC_W-1:0] PC_WLOAD  = 4'd3;
  localparam logic [PC_W-1:0] PC_WRUN   = 4'd4;
  localparam logic [PC_W-1:0] PC_WSTORE = 4'd5;
  localparam logic [PC_W-1:0] PC_TEMIT  = 4'd6;
  localparam logic [PC_W-1:0] PC_TSCALE = 4'd7;
  localparam logic [PC_W-1:0] PC_TNEG   = 4'd8;
  localparam logic [PC_W-1:0] PC_MUL10  = 4'd9;
  localparam logic [PC_W-1:0] PC_MLOAD  = 4'd10;
  localparam logic [PC_W-1:0] PC_MRUN   = 4'd11;
  localparam logic [PC_W-1:0] PC_MSTORE = 4'd12;
  localparam logic [PC_W-1:0] PC_OWAIT  = 4'd13;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd14;

  // jump to target when cond holds, else fall through to the next step
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      PC_FETCH:  w = '{OP_FETCH,    C_NO_XFER,  PC_FETCH};
      PC_DECODE: w = '{OP_DECODE,   C_NEXT,     PC_FETCH};
      PC_TFRAC:  w = '{OP_NOP,      C_NO_FRAC,  PC_TEMIT};
      PC_WLOAD:  w = '{OP_LOAD_W,   C_NEXT,     PC_FETCH};
      PC_WRUN:   w = '{OP_DIV_STEP, C_DIV_MORE, PC_WRUN};
      PC_WSTORE: w = '{OP_STORE_W,  C_NEXT,     PC_FETCH};
      PC_TEMIT:  w = '{OP_NOP,      C_NO_EMIT,  PC_FETCH};
      PC_TSCALE: w = '{OP_NOP,      C_EXP_DONE, PC_OWAIT};
      PC_TNEG:   w = '{OP_NOP,      C_EXP_NEG,  PC_MLOAD};
      PC_MUL10:  w = '{OP_MUL10,    C_ALWAYS,   PC_TSCALE};
      PC_MLOAD:  w = '{OP_LOAD_M,   C_NEXT,     PC_FETCH};
      PC_MRUN:   w = '{OP_DIV_STEP, C_DIV_MORE, PC_MRUN};
      PC_MSTORE: w = '{OP_STORE_M,  C_ALWAYS,   PC_TSCALE};
      PC_OWAIT:  w = '{OP_NOP,      C_OUT_BUSY, PC_OWAIT};
      PC_EMIT:   w = '{OP_EMIT,     C_ALWAYS,   PC_FETCH};
      default:   w = '{OP_NOP,      C_ALWAYS,   PC_FETCH};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dttf_if.sv =====
// Valid/ready channel interfaces for the character input and the number result.
`default_nettype none
interface dttf_in_if;
  logic                        valid;
  logic                        ready;
  logic [dttf_pkg::TEXT_W-1:0] text_char;
  logic                        field_start;

  modport source (output valid, output text_char, output field_start, input ready);
  modport sink   (input valid, input text_char, input field_start, output ready);
endinterface

interface dttf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dttf_pkg::VALUE_W-1:0] value;
  logic                                parse_ok;
  logic [dttf_pkg::COUNT_W-1:0]        chars_consumed;

  modport source (output valid, output value, output parse_ok, output chars_consumed,
                  input ready);
  modport sink   (input valid, input value, input parse_ok, input chars_consumed,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/decimal_text_to_fixed_point.sv =====
// Decimal text scanner: microcoded sequencer turning characters into Q fixed point.
//
// in_ch carries one character per transfer; field_start marks the first character
// of a new number field. out_ch gives one result per field: the value in signed
// fixed point (FRAC_BITS fraction bits, VALUE_BITS total, sign extended to 64),
// parse_ok and the number of characters consumed.
// A 15-step program in a constant table sequences a plain datapath.
// The scanner takes one character at a time and fetches the next only after the
// current one is handled; a fraction digit also sends the weight through the
// 8-bit-per-cycle divide-by-ten unit (NCH = ceil(max(VALUE_BITS, FRAC_BITS)/8)
// bytes, 8 at the defaults).
// At a field end the value is scaled by the exponent, if any: multiplied by ten
// per positive exponent unit or divided by ten per negative unit, up to 99 units;
// then the result register loads and the next character is taken.
// The result sits in an output register; the scanner keeps taking characters
// while it waits and only holds at the next field end if it is still untaken.
// Reset (synchronous, rst_n low) returns to the fetch step, idle, output empty.
`default_nettype none
module decimal_text_to_fixed_point #(
  parameter int FRAC_BITS  = 32,
  parameter int VALUE_BITS = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  dttf_in_if.sink      in_ch,
  dttf_out_if.source   out_ch
);

  localparam int DW  = (VALUE_BITS > FRAC_BITS) ? VALUE_BITS : FRAC_BITS;
  localparam int NCH = (DW + 7) / 8;
  localparam int PW  = NCH * 8;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int W   = ((VALUE_BITS + 3 > FRAC_BITS + 4) ? VALUE_BITS + 3 : FRAC_BITS + 4) + 1;
  localparam int FPW = FRAC_BITS + 4;

  localparam logic [W-1:0]          CAP_W = W'(1) << (VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] CAP_V = CAP_W[VALUE_BITS-1:0];
  localparam logic [FRAC_BITS-1:0]  TENTH = FRAC_BITS'((64'd1 << FRAC_BITS) / 10);
  localparam logic [CW-1:0]         LAST  = CW'(NCH - 1);

  localparam int TW = dttf_pkg::TEXT_W;
  localparam int KW = dttf_pkg::COUNT_W;
  localparam int EW = dttf_pkg::EXP_W;
  localparam int VALUE_W_C = dttf_pkg::VALUE_W;

  // sequencer
  logic [dttf_pkg::PC_W-1:0] pc_r;
  logic [dttf_pkg::PC_W-1:0] pc_nxt;
  dttf_pkg::ctrl_t           uw;
  logic                      jump;

  // parser state
  logic [TW-1:0]          char_r;
  logic                   start_r;
  dttf_pkg::phase_t       phase_r;
  logic                   neg_r;
  logic [VALUE_BITS-1:0]  acc_r;
  logic [FRAC_BITS-1:0]   wgt_r;
  logic [EW-1:0]          exp_r;
  logic                   eneg_r;
  logic [KW-1:0]          cnt_r;
  logic                   ok_r;
  logic                   frac_pend_r;
  logic                   emit_pend_r;
  logic                   scale_pend_r;

  // divide-by-ten unit
  logic [PW-1:0]          div_n_r;
  logic [PW-1:0]          div_n_nxt;
  logic [3:0]             div_rem_r;
  logic [3:0]             div_rem_nxt;
  logic [CW-1:0]          div_cnt_r;

  // output register
  logic                   out_valid_r;
  logic [VALUE_W_C-1:0]   out_value_r;
  logic                   out_ok_r;
  logic [KW-1:0]          out_cnt_r;

  // decode results
  dttf_pkg::phase_t       ph_b;
  dttf_pkg::phase_t       d_phase;
  logic [VALUE_BITS-1:0]  acc_b;
  logic [FRAC_BITS-1:0]   wgt_b;
  logic [EW-1:0]          exp_b;
  logic [KW-1:0]          cnt_b;
  logic                   d_neg;
  logic [VALUE_BITS-1:0]  d_acc;
  logic [EW-1:0]          d_exp;
  logic                   d_eneg;
  logic [KW-1:0]          d_cnt;
  logic                   d_ok;
  logic                   d_frac;
  logic                   d_emit;
  logic                   d_scale;
  logic [1:0]             d_add;
  logic [3:0]             dig;
  logic                   is_dig;
  logic                   is_white;
  logic                   is_sign;
  logic                   is_e;
  logic                   is_dot;
  logic [W-1:0]           int_sum;
  logic [VALUE_BITS-1:0]  int_acc;
  logic [FPW-1:0]         fprod;
  logic [W-1:0]           frac_sum;
  logic [VALUE_BITS-1:0]  frac_acc;
  logic [W-1:0]           m10;
  logic [VALUE_BITS-1:0]  m10_acc;
  logic [KW:0]            csum;
  logic [VALUE_BITS-1:0]  mag_out;
  logic signed [VALUE_BITS-1:0] val_out;

  assign uw = dttf_pkg::ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      dttf_pkg::C_NEXT:     jump = 1'b0;
      dttf_pkg::C_ALWAYS:   jump = 1'b1;
      dttf_pkg::C_NO_XFER:  jump = !in_ch.valid;
      dttf_pkg::C_NO_FRAC:  jump = !frac_pend_r;
      dttf_pkg::C_DIV_MORE: jump = (div_cnt_r != LAST);
      dttf_pkg::C_NO_EMIT:  jump = !emit_pend_r;
      dttf_pkg::C_EXP_DONE: jump = !scale_pend_r || (exp_r == '0);
      dttf_pkg::C_EXP_NEG:  jump = eneg_r;
      dttf_pkg::C_OUT_BUSY: jump = out_valid_r && !out_ch.ready;
      default:              jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.target : pc_r + 1'b1;
  end

  // character classes
  assign dig      = char_r[3:0];
  assign is_dig   = (char_r >= dttf_pkg::CH_ZERO) && (char_r <= dttf_pkg::CH_NINE);
  assign is_white = (char_r == dttf_pkg::CH_SPACE) ||
                    ((char_r >= dttf_pkg::CH_TAB) && (char_r <= dttf_pkg::CH_CR));
  assign is_sign  = (char_r == dttf_pkg::CH_MINUS) || (char_r == dttf_pkg::CH_PLUS);
  assign is_e     = (char_r == dttf_pkg::CH_E_LO) || (char_r == dttf_pkg::CH_E_UP);
  assign is_dot   = (char_r == dttf_pkg::CH_DOT);

  // a field start clears the field before the character is applied
  assign ph_b  = start_r ? dttf_pkg::PH_SPACE : phase_r;
  assign acc_b = start_r ? '0 : acc_r;
  assign wgt_b = start_r ? TENTH : wgt_r;
  assign exp_b = start_r ? '0 : exp_r;
  assign cnt_b = start_r ? '0 : cnt_r;

  // integer digit: acc*10 + d, saturating at the magnitude cap
  assign int_sum = (W'(acc_b) << 3) + (W'(acc_b) << 1) + (W'(dig) << FRAC_BITS);
  assign int_acc = (int_sum > CAP_W) ? CAP_V : int_sum[VALUE_BITS-1:0];

  // fraction digit: acc + d*weight, saturating
  assign fprod    = FPW'(dig) * FPW'(wgt_b);
  assign frac_sum = W'(acc_b) + W'(fprod);
  assign frac_acc = (frac_sum > CAP_W) ? CAP_V : frac_sum[VALUE_BITS-1:0];

  // exponent scaling step up
  assign m10     = (W'(acc_r) << 3) + (W'(acc_r) << 1);
  assign m10_acc = (m10 > CAP_W) ? CAP_V : m10[VALUE_BITS-1:0];

  always_comb begin
    d_phase = ph_b;
    d_neg   = start_r ? 1'b0 : neg_r;
    d_acc   = acc_b;
    d_exp   = exp_b;
    d_eneg  = start_r ? 1'b0 : eneg_r;
    d_ok    = start_r ? 1'b0 : ok_r;
    d_add   = 2'd0;
    d_frac  = 1'b0;
    d_emit  = 1'b0;
    d_scale = 1'b0;
    unique case (ph_b)
      dttf_pkg::PH_SPACE: begin
        if (is_white) begin
          d_add = 2'd1;
        end else if (is_dig) begin
          d_ok    = 1'b1;
          d_acc   = int_acc;
          d_add   = 2'd1;
          d_phase = dttf_pkg::PH_INT;
        end else if (is_sign) begin
          d_ok    = 1'b1;
          d_neg   = (char_r == dttf_pkg::CH_MINUS);
          d_add   = 2'd1;
          d_phase = dttf_pkg::PH_INT;
        end else if (is_e) begin
          d_phase = dttf_pkg::PH_EXP_E;
        end else begin
          d_emit  = 1'b1;
          d_phase = dttf_pkg::PH_IDLE;
        end
      end
      dttf_pkg::PH_INT: begin
        if (is_dig) begin
          d_acc = int_acc;
          d_add = 2'd1;
        end else if (is_dot) begin
          d_add   = 2'd1;
          d_phase = dttf_pkg::PH_FRAC;
        end else if (is_e) begin
          d_phase = dttf_pkg::PH_EXP_E;
        end else begin
          d_emit  = 1'b1;
          d_phase = dttf_pkg::PH_IDLE;
        end
      end
      dttf_pkg::PH_FRAC: begin
        if (is_dig) begin
          d_acc  = frac_acc;
          d_add  = 2'd1;
          d_frac = 1'b1;
        end else if (is_e) begin
          d_phase = dttf_pkg::PH_EXP_E;
        end else begin
          d_emit  = 1'b1;
          d_phase = dttf_pkg::PH_IDLE;
        end
      end
      dttf_pkg::PH_EXP_E: begin
        if (is_sign) begin
          d_eneg  = (char_r == dttf_pkg::CH_MINUS);
          d_phase = dttf_pkg::PH_EXP_SIGN;
        end else if (is_dig) begin
          d_exp   = EW'(dig);
          d_add   = 2'd2;
          d_phase = dttf_pkg::PH_EXP_D1;
        end else begin
          d_emit  = 1'b1;
          d_phase = dttf_pkg::PH_IDLE;
        end
      end
      dttf_pkg::PH_EXP_SIGN: begin
        if (is_dig) begin
          d_exp   = EW'(dig);
          d_add   = 2'd3;
          d_phase = dttf_pkg::PH_EXP_D1;
        end else begin
          d_emit  = 1'b1;
          d_phase = dttf_pkg::PH_IDLE;
        end
      end
      dttf_pkg::PH_EXP_D1: begin
        // any character here closes the field; a second exponent digit is also consumed
        if (is_dig) begin
          d_exp = (exp_b << 3) + (exp_b << 1) + EW'(dig);
          d_add = 2'd1;
        end
        d_emit  = 1'b1;
        d_scale = 1'b1;
        d_phase = dttf_pkg::PH_IDLE;
      end
      default: d_phase = dttf_pkg::PH_IDLE;
    endcase
    csum  = {1'b0, cnt_b} + (KW + 1)'(d_add);
    d_cnt = (csum > (KW + 1)'(255)) ? KW'(255) : csum[KW-1:0];
  end

  // divide-by-ten, one byte of the dividend per cycle, MSB first
  always_comb begin
    logic [4:0] r;
    logic [7:0] top;
    logic [7:0] qb;
    top = div_n_r[PW-1 -: 8];
    r   = {1'b0, div_rem_r};
    qb  = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[3:0], top[i]};
      if (r >= 5'd10) begin
        r     = r - 5'd10;
        qb[i] = 1'b1;
      end
    end
    div_rem_nxt = r[3:0];
    div_n_nxt   = {div_n_r[PW-9:0], qb};
  end

  // result: clamp positive overflow, negate in VALUE_BITS, sign extend
  assign mag_out = (!neg_r && (acc_r == CAP_V)) ? CAP_V - 1'b1 : acc_r;
  assign val_out = neg_r ? -mag_out : mag_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= dttf_pkg::PC_FETCH;
      phase_r      <= dttf_pkg::PH_IDLE;
      start_r      <= 1'b0;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      wgt_r        <= TENTH;
      exp_r        <= '0;
      eneg_r       <= 1'b0;
      cnt_r        <= '0;
      ok_r         <= 1'b0;
      frac_pend_r  <= 1'b0;
      emit_pend_r  <= 1'b0;
      scale_pend_r <= 1'b0;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (uw.op)
        dttf_pkg::OP_FETCH: begin
          if (in_ch.valid) begin
            char_r  <= in_ch.text_char;
            start_r <= in_ch.field_start;
          end
        end
        dttf_pkg::OP_DECODE: begin
          phase_r      <= d_phase;
          neg_r        <= d_neg;
          acc_r        <= d_acc;
          wgt_r        <= wgt_b;
          exp_r        <= d_exp;
          eneg_r       <= d_eneg;
          cnt_r        <= d_cnt;
          ok_r         <= d_ok;
          frac_pend_r  <= d_frac;
          emit_pend_r  <= d_emit;
          scale_pend_r <= d_scale;
        end
        dttf_pkg::OP_LOAD_W: begin
          div_n_r   <= PW'(wgt_r);
          div_rem_r <= '0;
          div_cnt_r <= '0;
        end
        dttf_pkg::OP_LOAD_M: begin
          div_n_r   <= PW'(acc_r);
          div_rem_r <= '0;
          div_cnt_r <= '0;
          exp_r     <= exp_r - 1'b1;
        end
        dttf_pkg::OP_DIV_STEP: begin
          div_n_r   <= div_n_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        dttf_pkg::OP_STORE_W: wgt_r <= div_n_r[FRAC_BITS-1:0];
        dttf_pkg::OP_STORE_M: acc_r <= div_n_r[VALUE_BITS-1:0];
        dttf_pkg::OP_MUL10: begin
          acc_r <= m10_acc;
          exp_r <= exp_r - 1'b1;
        end
        dttf_pkg::OP_EMIT: begin
          out_valid_r <= 1'b1;
          out_value_r <= VALUE_W_C'(val_out);
          out_ok_r    <= ok_r;
          out_cnt_r   <= cnt_r;
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready           = (uw.op == dttf_pkg::OP_FETCH);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.value          = out_value_r;
  assign out_ch.parse_ok       = out_ok_r;
  assign out_ch.chars_consumed = out_cnt_r;

endmodule
`default_nettype wire
